// File: hdl/cdl_pkg.sv
// ----------------------------------------------------------------------------
// cdl_pkg
// Shared sizes, codes and types of the circular doubly linked list engine.
// ----------------------------------------------------------------------------
package cdl_pkg;

	localparam int CAPACITY = 32;
	localparam int DATA_W   = 32;

	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int ACT_W  = 3;
	localparam int ST_W   = 2;
	localparam int OUT_DW = 32;
	localparam int LEN_W  = 6;
	localparam int LINK_W = 2 * IDX_W;
	localparam int WIDE_W = (DATA_W > OUT_DW) ? DATA_W : OUT_DW;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH  = 3'd0,
		ACT_POP   = 3'd1,
		ACT_LIST  = 3'd2,
		ACT_PREV  = 3'd3,
		ACT_NEXT  = 3'd4,
		ACT_CLEAR = 3'd5
	} action_t;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [DATA_W-1:0] data_t;

	typedef struct packed {
		idx_t prv;
		idx_t nxt;
	} link_t;

	typedef struct packed {
		logic  we;
		idx_t  waddr;
		link_t wdata;
		logic  re;
		idx_t  raddr;
	} link_req_t;

	typedef struct packed {
		logic  we;
		idx_t  waddr;
		data_t wdata;
		logic  re;
		idx_t  raddr;
	} pay_req_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [OUT_DW-1:0] item_data;
		logic              item_valid;
		logic [OUT_DW-1:0] current_data;
		logic              current_valid;
		logic [LEN_W-1:0]  length;
		logic              last;
	} result_t;

	function automatic logic [OUT_DW-1:0] out_word(input data_t d);
		logic [WIDE_W-1:0] w;
		w = WIDE_W'(d);
		return w[OUT_DW-1:0];
	endfunction

endpackage

// File: hdl/cdl_ram.sv
// ----------------------------------------------------------------------------
// cdl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cdl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/cdl_seq.sv
// ----------------------------------------------------------------------------
// cdl_seq
// Action sequencer: walks the link and payload memories, keeps cursor,
// element count and the free slot chain, and presents results.
// ----------------------------------------------------------------------------
module cdl_seq
	import cdl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [ACT_W-1:0]     action,
	input  logic [OUT_DW-1:0]    payload,
	output link_req_t            link_req,
	input  link_t                link_rd,
	output pay_req_t             pay_req,
	input  data_t                pay_rd,
	input  logic                 out_rdy,
	output logic                 res_vld,
	output result_t              res
);

	typedef enum logic [11:0] {
		S_IDLE      = 12'b000000000001,
		S_PUSH_FREE = 12'b000000000010,
		S_PUSH_LNK  = 12'b000000000100,
		S_PUSH_C    = 12'b000000001000,
		S_PUSH_A    = 12'b000000010000,
		S_POP_LNK   = 12'b000000100000,
		S_POP_B     = 12'b000001000000,
		S_POP_A     = 12'b000010000000,
		S_MOVE_LNK  = 12'b000100000000,
		S_MOVE_DAT  = 12'b001000000000,
		S_LIST      = 12'b010000000000,
		S_EMIT      = 12'b100000000000
	} state_t;

	state_t          state_q;
	idx_t            cursor_q;
	cnt_t            count_q;
	cnt_t            fresh_q;
	idx_t            fhead_q;
	data_t           cur_data_q;
	data_t           data_q;
	idx_t            n_q;
	idx_t            prv_q;
	idx_t            after_q;
	link_t           lnk_q;
	logic            move_prev_q;
	cnt_t            rem_q;
	logic [ST_W-1:0] res_status_q;
	data_t           res_item_q;
	logic            res_iv_q;

	logic full;
	logic fresh_left;
	idx_t move_tgt;

	assign full       = (count_q == CNT_W'(CAPACITY));
	assign fresh_left = (fresh_q != CNT_W'(CAPACITY));
	assign move_tgt   = move_prev_q ? link_rd.prv : link_rd.nxt;
	assign in_stall   = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cursor_q <= '0;
			count_q  <= '0;
			fresh_q  <= '0;
			fhead_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						res_status_q <= ST_OK;
						res_iv_q     <= 1'b0;
						case (action)
							ACT_CLEAR: begin
								count_q  <= '0;
								cursor_q <= '0;
								fresh_q  <= '0;
								state_q  <= S_EMIT;
							end
							ACT_PUSH: begin
								data_q <= DATA_W'(payload);
								if (full) begin
									res_status_q <= ST_FULL;
									state_q      <= S_EMIT;
								end else if (fresh_left) begin
									n_q     <= fresh_q[IDX_W-1:0];
									fresh_q <= fresh_q + CNT_W'(1);
									state_q <= S_PUSH_LNK;
								end else begin
									state_q <= S_PUSH_FREE;
								end
							end
							ACT_POP, ACT_LIST, ACT_PREV, ACT_NEXT: begin
								if (count_q == '0) begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_EMIT;
								end else if (action == ACT_POP) begin
									state_q <= S_POP_LNK;
								end else if (action == ACT_LIST) begin
									rem_q   <= count_q;
									state_q <= S_LIST;
								end else begin
									move_prev_q <= (action == ACT_PREV);
									state_q     <= S_MOVE_LNK;
								end
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_PUSH_FREE: begin
					n_q     <= fhead_q;
					fhead_q <= link_rd.nxt;
					state_q <= S_PUSH_LNK;
				end
				S_PUSH_LNK: begin
					if (count_q == '0) begin
						cursor_q     <= n_q;
						count_q      <= count_q + CNT_W'(1);
						cur_data_q   <= data_q;
						res_item_q   <= data_q;
						res_iv_q     <= 1'b1;
						state_q      <= S_EMIT;
					end else begin
						prv_q   <= link_rd.prv;
						after_q <= link_rd.nxt;
						state_q <= S_PUSH_C;
					end
				end
				S_PUSH_C: begin
					lnk_q   <= link_rd;
					state_q <= S_PUSH_A;
				end
				S_PUSH_A: begin
					cursor_q   <= n_q;
					count_q    <= count_q + CNT_W'(1);
					cur_data_q <= data_q;
					res_item_q <= data_q;
					res_iv_q   <= 1'b1;
					state_q    <= S_EMIT;
				end
				S_POP_LNK: begin
					// the popped slot goes on top of the free chain
					fhead_q    <= cursor_q;
					prv_q      <= link_rd.prv;
					after_q    <= link_rd.nxt;
					res_item_q <= cur_data_q;
					res_iv_q   <= 1'b1;
					if (count_q == CNT_W'(1)) begin
						cursor_q <= '0;
						count_q  <= '0;
						state_q  <= S_EMIT;
					end else begin
						state_q <= S_POP_B;
					end
				end
				S_POP_B: begin
					state_q <= S_POP_A;
				end
				S_POP_A: begin
					cur_data_q <= pay_rd;
					cursor_q   <= after_q;
					count_q    <= count_q - CNT_W'(1);
					state_q    <= S_EMIT;
				end
				S_MOVE_LNK: begin
					cursor_q <= move_tgt;
					state_q  <= S_MOVE_DAT;
				end
				S_MOVE_DAT: begin
					cur_data_q <= pay_rd;
					res_item_q <= pay_rd;
					res_iv_q   <= 1'b1;
					state_q    <= S_EMIT;
				end
				S_LIST: begin
					if (out_rdy) begin
						rem_q <= rem_q - CNT_W'(1);
						if (rem_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EMIT: begin
					if (out_rdy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// memory requests
	always_comb begin
		link_req = '0;
		pay_req  = '0;
		case (state_q)
			S_IDLE: begin
				link_req.re    = 1'b1;
				link_req.raddr = (action == ACT_PUSH && !fresh_left) ? fhead_q : cursor_q;
				pay_req.re     = 1'b1;
				pay_req.raddr  = cursor_q;
			end
			S_PUSH_FREE: begin
				link_req.re    = 1'b1;
				link_req.raddr = cursor_q;
			end
			S_PUSH_LNK: begin
				pay_req.we    = 1'b1;
				pay_req.waddr = n_q;
				pay_req.wdata = data_q;
				link_req.we    = 1'b1;
				link_req.waddr = n_q;
				if (count_q == '0) begin
					link_req.wdata.prv = n_q;
					link_req.wdata.nxt = n_q;
				end else begin
					link_req.wdata.prv = cursor_q;
					link_req.wdata.nxt = link_rd.nxt;
				end
				link_req.re    = 1'b1;
				link_req.raddr = link_rd.nxt;
			end
			S_PUSH_C: begin
				link_req.we    = 1'b1;
				link_req.waddr = cursor_q;
				// with one element the old node links to the new one both ways
				link_req.wdata.prv = (after_q == cursor_q) ? n_q : prv_q;
				link_req.wdata.nxt = n_q;
			end
			S_PUSH_A: begin
				link_req.we        = (after_q != cursor_q);
				link_req.waddr     = after_q;
				link_req.wdata.prv = n_q;
				link_req.wdata.nxt = lnk_q.nxt;
			end
			S_POP_LNK: begin
				link_req.we        = 1'b1;
				link_req.waddr     = cursor_q;
				link_req.wdata.prv = link_rd.prv;
				link_req.wdata.nxt = fhead_q;
				link_req.re        = 1'b1;
				link_req.raddr     = link_rd.prv;
			end
			S_POP_B: begin
				link_req.we    = 1'b1;
				link_req.waddr = prv_q;
				// two elements left: the survivor points at itself
				link_req.wdata.prv = (prv_q == after_q) ? prv_q : link_rd.prv;
				link_req.wdata.nxt = after_q;
				link_req.re    = 1'b1;
				link_req.raddr = after_q;
				pay_req.re     = 1'b1;
				pay_req.raddr  = after_q;
			end
			S_POP_A: begin
				link_req.we        = (prv_q != after_q);
				link_req.waddr     = after_q;
				link_req.wdata.prv = prv_q;
				link_req.wdata.nxt = link_rd.nxt;
			end
			S_MOVE_LNK: begin
				pay_req.re    = 1'b1;
				pay_req.raddr = move_tgt;
			end
			S_LIST: begin
				// read data holds while the output is stalled
				link_req.re    = out_rdy;
				link_req.raddr = link_rd.nxt;
				pay_req.re     = out_rdy;
				pay_req.raddr  = link_rd.nxt;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_vld           = 1'b0;
		res               = '0;
		res.current_valid = (count_q != '0);
		res.current_data  = (count_q != '0) ? out_word(cur_data_q) : '0;
		res.length        = LEN_W'(count_q);
		case (state_q)
			S_EMIT: begin
				res_vld        = 1'b1;
				res.status     = res_status_q;
				res.item_valid = res_iv_q;
				res.item_data  = res_iv_q ? out_word(res_item_q) : '0;
				res.last       = 1'b1;
			end
			S_LIST: begin
				res_vld        = 1'b1;
				res.status     = ST_OK;
				res.item_valid = 1'b1;
				res.item_data  = out_word(pay_rd);
				res.last       = (rem_q == CNT_W'(1));
			end
			default: begin
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= CNT_W'(CAPACITY))
		else $error("fresh slot counter above capacity");

	a_list_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LIST |-> rem_q != '0 && rem_q <= count_q)
		else $error("list walk count out of range");

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP_LNK || state_q == S_MOVE_LNK) |-> count_q != '0)
		else $error("link walk on an empty list");

	a_list_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld && out_rdy && res.last) |=> state_q == S_IDLE)
		else $error("sequencer busy after final result");

endmodule

// File: hdl/cdl_out_reg.sv
// ----------------------------------------------------------------------------
// cdl_out_reg
// Output register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module cdl_out_reg
	import cdl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_vld,
	input  result_t res,
	output logic    out_rdy,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_q
);

	logic valid_q;

	assign out_rdy   = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_rdy) begin
			valid_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && res_vld) begin
			out_q <= res;
		end
	end

endmodule

// File: hdl/circular_doubly_linked_list_engine.sv
// Clear, refused push and empty-list actions emit their result directly; prev/next
// reads the link, then the payload; push writes the new node and relinks its
// neighbours (only itself into an empty list, after a free chain read once recycled
// slots are reused); pop unlinks the cursor node. One action at a time: the next
// item is accepted the cycle after the last result is taken.
// Reset clears cursor, count and slot allocator at once; memories are not cleared.
// ----------------------------------------------------------------------------
// circular_doubly_linked_list_engine
// Bounded circular doubly linked list in slot memories with a cursor.
// ----------------------------------------------------------------------------
module circular_doubly_linked_list_engine
	import cdl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ACT_W-1:0]  action,
	input  logic [OUT_DW-1:0] payload,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ST_W-1:0]   status,
	output logic [OUT_DW-1:0] item_data,
	output logic              item_valid,
	output logic [OUT_DW-1:0] current_data,
	output logic              current_valid,
	output logic [LEN_W-1:0]  length,
	output logic              last
);

	link_req_t link_req;
	pay_req_t  pay_req;
	link_t     link_rd;
	data_t     pay_rd;
	logic      out_rdy;
	logic      res_vld;
	result_t   res;
	result_t   out_q;

	cdl_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.payload  (payload),
		.link_req (link_req),
		.link_rd  (link_rd),
		.pay_req  (pay_req),
		.pay_rd   (pay_rd),
		.out_rdy  (out_rdy),
		.res_vld  (res_vld),
		.res      (res)
	);

	cdl_ram #(
		.WIDTH (LINK_W),
		.DEPTH (CAPACITY)
	) u_link_ram (
		.clk   (clk),
		.we    (link_req.we),
		.waddr (link_req.waddr),
		.wdata (link_req.wdata),
		.re    (link_req.re),
		.raddr (link_req.raddr),
		.rdata (link_rd)
	);

	cdl_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_pay_ram (
		.clk   (clk),
		.we    (pay_req.we),
		.waddr (pay_req.waddr),
		.wdata (pay_req.wdata),
		.re    (pay_req.re),
		.raddr (pay_req.raddr),
		.rdata (pay_rd)
	);

	cdl_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_vld   (res_vld),
		.res       (res),
		.out_rdy   (out_rdy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_q     (out_q)
	);

	assign status        = out_q.status;
	assign item_data     = out_q.item_data;
	assign item_valid    = out_q.item_valid;
	assign current_data  = out_q.current_data;
	assign current_valid = out_q.current_valid;
	assign length        = out_q.length;
	assign last          = out_q.last;

endmodule
